// ===== rtl/core/ordl_pkg.sv =====
// ordl_pkg: operation codes, field widths and the control bundle
// shared by the ordered list top level and its storage cells
// no dependencies
`default_nettype none

package ordl_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FIDX_W  = 5;
  localparam int unsigned OCNT_W  = 6;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // broadcast to every cell in the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
  } ordl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ordered_list_insert_delete.sv =====
// ordered_list_insert_delete: bounded ordered list of signed words
// built as a row of ordl_cell instances with a two-stage result path
// depends on ordl_pkg, ordl_cell
//
// channel  dir  fields (lsb first)
// in       in   tuser: operation[2:0]; tdata: position[5:0], item_value[37:6]
// out      out  tdata: success[0], read_value[32:1], found_index[37:33],
//                      entry_count[43:38], list_empty[44]
//
// one item per cycle unless stalled; list update and per-cell compares
// happen at accept; result registered in compare stage, then encode stage
// the first-match encode over all cells sets the second stage
// synchronous active-low reset empties the list; entry words are not cleared
// a stalled output holds the compare stage, which then holds the input
`default_nettype none

module ordered_list_insert_delete
  import ordl_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // position, item_value
  input  wire logic [OP_W-1:0]        in_tuser,   // operation
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // success, read_value,
                                                  // found_index, entry_count,
                                                  // list_empty
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic              in_acc;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] val;
  logic [PW-1:0]     pos_x;
  logic [PW-1:0]     cnt_x;
  logic              get_ok;
  logic              del_ok;
  logic              ins_ok;
  logic              is_loc;
  logic              ok;
  ordl_ctrl_t        ctrl;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic [WORD_W-1:0] entry_w [CAPACITY];
  logic [WORD_W-1:0] sel_w   [CAPACITY];
  logic [CAPACITY-1:0] hit_w;
  logic [WORD_W-1:0] rd_any;

  logic                s1_valid_r;
  logic                s1_loc_r;
  logic                s1_ok_r;
  logic [WORD_W-1:0]   s1_rd_r;
  logic [CAPACITY-1:0] s1_hits_r;
  logic [CNT_W-1:0]    s1_cnt_r;
  logic                s1_adv;

  logic [CAPACITY-1:0] first_hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                s2_ok;

  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign op  = in_tuser;
  assign pos = in_tdata[POS_W-1:0];
  assign val = in_tdata[POS_W +: WORD_W];

  assign pos_x  = PW'(pos);
  assign cnt_x  = PW'(count_r);
  assign get_ok = (op == OP_GET) && (pos_x < cnt_x);
  assign del_ok = (op == OP_DELETE) && (pos_x < cnt_x);
  assign ins_ok = (op == OP_INSERT) && (cnt_x < PW'(CAPACITY)) && (pos_x <= cnt_x);
  assign is_loc = (op == OP_LOCATE);
  assign ok     = get_ok || del_ok || ins_ok || (op == OP_CLEAR);

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    ctrl.ins = in_acc && ins_ok;
    ctrl.del = in_acc && del_ok;
    ctrl.pos = pos;
    ctrl.val = val;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    if (i == 0) begin : g_lo_edge
      assign lower = '0;
    end else begin : g_lo
      assign lower = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_edge
      assign upper = '0;
    end else begin : g_hi
      assign upper = entry_w[i+1];
    end
    ordl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (count_r),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry_w[i]),
      .hit_o   (hit_w[i]),
      .sel_o   (sel_w[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | sel_w[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      if (ins_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (del_ok) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (op == OP_CLEAR) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_loc_r  <= is_loc;
      s1_ok_r   <= ok;
      s1_rd_r   <= (get_ok || del_ok) ? rd_any : '0;
      s1_hits_r <= is_loc ? hit_w : '0;
      s1_cnt_r  <= count_nxt;
    end
  end

  // first-match encode
  always_comb begin
    first_hit = s1_hits_r & (~s1_hits_r + CAPACITY'(1));
    hit_idx   = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    s2_ok = s1_loc_r ? (|s1_hits_r) : s1_ok_r;
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[0]     = s2_ok;
    out_data_nxt[32:1]  = s1_rd_r;
    out_data_nxt[37:33] = FIDX_W'(hit_idx);
    out_data_nxt[43:38] = OCNT_W'(s1_cnt_r);
    out_data_nxt[44]    = (s1_cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_valid_r)
    else $error("result pending after reset");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ins_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_CLEAR) |=> count_r == '0)
    else $error("clear left entries");

  a_loc_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_loc_r |-> s1_hits_r == '0)
    else $error("match bits set for a non-locate item");

endmodule

`default_nettype wire

// ===== rtl/core/ordl_cell.sv =====
// ordl_cell: one list position; holds one entry, shifts from its
// lower or upper neighbor, compares against the searched value
// depends on ordl_pkg
`default_nettype none

module ordl_cell
  import ordl_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6
) (
  input  wire logic              clk,
  input  wire ordl_ctrl_t        ctrl,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic [WORD_W-1:0] lower_i,
  input  wire logic [WORD_W-1:0] upper_i,
  output logic [WORD_W-1:0]      entry_o,
  output logic                   hit_o,
  output logic [WORD_W-1:0]      sel_o
);

  localparam int unsigned PW = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [WORD_W-1:0] entry_r;
  logic [WORD_W-1:0] entry_nxt;
  logic              at_pos;
  logic              above_pos;
  logic              in_list;

  assign at_pos    = PW'(IDX) == PW'(ctrl.pos);
  assign above_pos = PW'(IDX) >  PW'(ctrl.pos);
  assign in_list   = CNT_W'(IDX) < count;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (at_pos) begin
        entry_nxt = ctrl.val;
      end else if (above_pos) begin
        entry_nxt = lower_i;
      end
    end else if (ctrl.del) begin
      if (at_pos || above_pos) begin
        entry_nxt = upper_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign hit_o   = in_list && (entry_r == ctrl.val);
  assign sel_o   = at_pos ? entry_r : '0;

endmodule

`default_nettype wire
